### rtl/aabbfc_pkg.sv
package aabbfc_pkg;

	localparam int NumPlanes = 6;
	localparam int CoordW    = 22;
	localparam int NormW     = 14;
	localparam int DistW     = 22;
	localparam int MarginW   = 16;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 64;
	// distance and margin move from 8 to 20 fraction bits
	localparam int FracShift = 12;
	localparam int ProdW     = NormW + CoordW;
	localparam int BiasW     = DistW + 1;
	localparam int SumW      = ProdW + 1;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [NormW-1:0]  norm_t;
	typedef logic signed [DistW-1:0]  dist_t;
	typedef logic signed [MarginW-1:0] margin_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} vec3_t;

	// register layout: distance on top, then nz, ny, nx in the low bits
	typedef struct packed {
		dist_t distance;
		norm_t nz;
		norm_t ny;
		norm_t nx;
	} plane_t;

	typedef enum logic [CfgIdxW-1:0] {
		RegLeft   = 3'd0,
		RegRight  = 3'd1,
		RegBottom = 3'd2,
		RegTop    = 3'd3,
		RegNear   = 3'd4,
		RegFar    = 3'd5,
		RegMargin = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic en1;
		logic en2;
	} stage_en_t;

endpackage

### rtl/aabbfc_regs.sv
module aabbfc_regs
	import aabbfc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output plane_t              planes [NumPlanes],
	output margin_t             margin
);

	plane_t  plane_q [NumPlanes];
	margin_t margin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumPlanes; i++) begin
				plane_q[i] <= '0;
			end
			margin_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegLeft, RegRight, RegBottom, RegTop, RegNear, RegFar: begin
					plane_q[cfg_index] <= plane_t'(cfg_data);
				end
				RegMargin: begin
					margin_q <= margin_t'(cfg_data[MarginW-1:0]);
				end
				default: begin
					// no register here, write is dropped
				end
			endcase
		end
	end

	assign planes = plane_q;
	assign margin = margin_q;

endmodule

### rtl/aabbfc_plane.sv
module aabbfc_plane
	import aabbfc_pkg::*;
(
	input  logic      clk,
	input  stage_en_t en,
	input  plane_t    plane,
	input  margin_t   margin,
	input  vec3_t     lo,
	input  vec3_t     hi,
	output logic      pass_s2
);

	coord_t px, py, pz;
	logic signed [ProdW-1:0] prod_x, prod_y, prod_z;
	logic signed [ProdW-1:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [BiasW-1:0] bias;
	logic signed [BiasW+FracShift-1:0] bias_q20;
	logic signed [SumW-1:0] sum;

	// positive vertex: high corner unless the normal component is negative
	assign px = plane.nx[NormW-1] ? lo.x : hi.x;
	assign py = plane.ny[NormW-1] ? lo.y : hi.y;
	assign pz = plane.nz[NormW-1] ? lo.z : hi.z;

	assign prod_x = ProdW'(plane.nx) * ProdW'(px);
	assign prod_y = ProdW'(plane.ny) * ProdW'(py);
	assign prod_z = ProdW'(plane.nz) * ProdW'(pz);

	always_ff @(posedge clk) begin
		if (en.en1) begin
			prod_x_s1 <= prod_x;
			prod_y_s1 <= prod_y;
			prod_z_s1 <= prod_z;
		end
	end

	assign bias     = BiasW'(plane.distance) + BiasW'(margin);
	assign bias_q20 = {bias, {FracShift{1'b0}}};
	assign sum      = SumW'(prod_x_s1) + SumW'(prod_y_s1) + SumW'(prod_z_s1)
		+ SumW'(bias_q20);

	always_ff @(posedge clk) begin
		if (en.en2) begin
			pass_s2 <= !sum[SumW-1];
		end
	end

endmodule

### rtl/aabb_frustum_cull_top.sv
// Frustum cull of an axis-aligned box, positive vertex test against six planes.
// One box is taken per clock while in_stall is low, and visible is presented from
// the output register once the box word has passed the stages. The three stages
// are the per-plane multipliers (18 of them, one per normal component), the exact
// four-term sum per plane, and the six-way combine into the output register.
// Stalls hold the pipeline stage by stage and empty stages fill, so in_stall
// rises only when every stage holds a word. Plane and margin registers are
// written through the cfg port, which is always ready; write them only while no
// box is in flight.
module aabb_frustum_cull_top
	import aabbfc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  coord_t              low_x,
	input  coord_t              low_y,
	input  coord_t              low_z,
	input  coord_t              high_x,
	input  coord_t              high_y,
	input  coord_t              high_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                visible
);

	plane_t    planes [NumPlanes];
	margin_t   margin;
	vec3_t     lo, hi;
	stage_en_t en;
	logic      en3;
	logic      v_s1, v_s2, v_s3;
	logic      visible_s3;
	logic [NumPlanes-1:0] pass_s2;

	aabbfc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes),
		.margin    (margin)
	);

	assign lo = '{x: low_x, y: low_y, z: low_z};
	assign hi = '{x: high_x, y: high_y, z: high_z};

	// a stage loads when it is empty or the next one moves
	assign en3    = !v_s3 || !out_stall;
	assign en.en2 = !v_s2 || en3;
	assign en.en1 = !v_s1 || en.en2;
	assign in_stall = !en.en1;

	for (genvar i = 0; i < NumPlanes; i++) begin : g_plane
		aabbfc_plane u_plane (
			.clk     (clk),
			.en      (en),
			.plane   (planes[i]),
			.margin  (margin),
			.lo      (lo),
			.hi      (hi),
			.pass_s2 (pass_s2[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.en1) begin
				v_s1 <= in_valid;
			end
			if (en.en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			visible_s3 <= &pass_s2;
		end
	end

	assign out_valid = v_s3;
	assign visible   = visible_s3;

endmodule

### rtl/aabbfc_checker.sv
module aabbfc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic visible
);

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(visible))
	else $error("result word changed while stalled");

	// with the output side empty the whole pipe can move
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
	else $error("input stalled with empty output stage");

	// an accepted box reaches out_valid when out_stall stays low behind it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
	else $error("accepted box did not reach the output");

endmodule

bind aabb_frustum_cull_top aabbfc_checker u_chk (.*);

### bench/testbench.sv
module testbench;
	import aabbfc_pkg::*;

	localparam int CMin = -2097152;
	localparam int CMax = 2097151;
	localparam int NormOne = 4096;
	localparam int NormMin = -8192;
	localparam int NormMax = 8191;
	localparam int DistOne = 256;
	localparam int MarginOne = 256;
	localparam int MarginMin = -32768;
	localparam int MarginMax = 32767;
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
	localparam int LongHold = 60;
	localparam int WatchdogLimit = 2000;
	localparam int BatchesPerPhase = 6;
	localparam int BoxesPerBatch = 103;

	typedef enum int {
		SetReset,
		SetLeftX,
		SetAllCulled,
		SetZeroSum,
		SetExtremeA,
		SetExtremeB
	} plane_set_t;

	// one directed box; typed rows carry their visible bit, the rest use the predictor
	typedef struct packed {
		plane_set_t pset;
		int lx;
		int ly;
		int lz;
		int hx;
		int hy;
		int hz;
		logic typed;
		logic vis;
	} box_row_t;

	localparam int NumRows = 21;
	box_row_t directed_boxes [NumRows] = '{
		'{SetReset, CMin, CMin, CMin, CMax, CMax, CMax, 1'b1, 1'b1},
		'{SetReset, CMax, CMax, CMax, CMin, CMin, CMin, 1'b1, 1'b1},
		'{SetReset, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1},
		'{SetLeftX, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1},
		'{SetLeftX, -5, 0, 0, -1, 0, 0, 1'b1, 1'b0},
		'{SetLeftX, 100, 0, 0, -5, 0, 0, 1'b1, 1'b0},
		'{SetLeftX, CMin, 0, 0, CMax, 0, 0, 1'b1, 1'b1},
		'{SetLeftX, CMin, CMin, CMin, CMin, CMax, CMax, 1'b1, 1'b0},
		'{SetLeftX, 7, -3, 9, 7, -3, 9, 1'b1, 1'b1},
		'{SetAllCulled, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0},
		'{SetAllCulled, CMin, CMin, CMin, CMax, CMax, CMax, 1'b1, 1'b0},
		'{SetZeroSum, CMax, CMax, CMax, CMin, CMin, CMin, 1'b1, 1'b1},
		'{SetZeroSum, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1},
		'{SetExtremeA, CMin, CMin, CMin, CMax, CMax, CMax, 1'b0, 1'b0},
		'{SetExtremeA, CMax, CMax, CMax, CMin, CMin, CMin, 1'b0, 1'b0},
		'{SetExtremeA, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
		'{SetExtremeA, -1, 1, -1, 1, -1, 1, 1'b0, 1'b0},
		'{SetExtremeB, CMin, CMin, CMin, CMax, CMax, CMax, 1'b0, 1'b0},
		'{SetExtremeB, CMax, CMax, CMax, CMin, CMin, CMin, 1'b0, 1'b0},
		'{SetExtremeB, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0},
		'{SetExtremeB, -1, 1, -1, 1, -1, 1, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t low_x = '0;
	coord_t low_y = '0;
	coord_t low_z = '0;
	coord_t high_x = '0;
	coord_t high_y = '0;
	coord_t high_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic visible;

	// shadow of the plane and margin registers
	plane_t [NumPlanes-1:0] plane_regs = '0;
	margin_t margin_reg = '0;

	logic pending_visible [$];
	int mismatches = 0;
	int results_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	aabb_frustum_cull_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.low_x(low_x),
		.low_y(low_y),
		.low_z(low_z),
		.high_x(high_x),
		.high_y(high_y),
		.high_z(high_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.visible(visible)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint vertex_product(input norm_t n, input coord_t lo, input coord_t hi);
		// zero normal counts as non-negative and takes the high corner
		if (n >= 0)
			return longint'(n) * longint'(hi);
		return longint'(n) * longint'(lo);
	endfunction

	function automatic logic box_visible(input vec3_t lo, input vec3_t hi);
		longint acc;
		dist_t d;
		logic vis;
		int p;
		vis = 1'b1;
		for (p = 0; p < NumPlanes; p++) begin
			d = plane_regs[p].distance;
			acc = vertex_product(plane_regs[p].nx, lo.x, hi.x)
				+ vertex_product(plane_regs[p].ny, lo.y, hi.y)
				+ vertex_product(plane_regs[p].nz, lo.z, hi.z)
				+ (longint'(d) <<< FracShift)
				+ (longint'(margin_reg) <<< FracShift);
			if (acc < 0)
				vis = 1'b0;
		end
		return vis;
	endfunction

	function automatic plane_t make_plane(input int nx, input int ny, input int nz, input int d);
		plane_t pl;
		pl.nx = norm_t'(nx);
		pl.ny = norm_t'(ny);
		pl.nz = norm_t'(nz);
		pl.distance = dist_t'(d);
		return pl;
	endfunction

	function automatic void rand_box(output vec3_t lo, output vec3_t hi);
		coord_t l [3];
		coord_t u [3];
		coord_t t;
		int kind;
		int c;
		int h;
		int a;
		kind = $urandom_range(9);
		for (a = 0; a < 3; a++) begin
			if (kind == 0) begin
				l[a] = coord_t'($urandom());
				u[a] = coord_t'($urandom());
			end else begin
				c = int'($urandom_range(0, 131072)) - 65536;
				h = (kind == 1) ? 0 : int'($urandom_range(0, 4096));
				l[a] = coord_t'(c - h);
				u[a] = coord_t'(c + h);
				// inverted corners
				if (kind == 2) begin
					t = l[a];
					l[a] = u[a];
					u[a] = t;
				end
			end
		end
		lo.x = l[0];
		lo.y = l[1];
		lo.z = l[2];
		hi.x = u[0];
		hi.y = u[1];
		hi.z = u[2];
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch at result %0d: %s", results_seen, msg);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < NumPlanes)
			plane_regs[idx] = data;
		else if (idx == RegMargin)
			margin_reg = data[MarginW-1:0];
	endtask

	task automatic load_config(input plane_t [NumPlanes-1:0] pl, input margin_t m);
		logic [CfgDataW-1:0] word;
		int r;
		for (r = 0; r < NumPlanes; r++)
			write_reg(CfgIdxW'(r), pl[r]);
		// upper bits of the margin word are junk
		word = {$urandom(), $urandom()};
		word[MarginW-1:0] = m;
		write_reg(RegMargin, word);
		if ($urandom_range(1))
			write_reg(RegUnused, {$urandom(), $urandom()});
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_set(input plane_set_t s);
		plane_t [NumPlanes-1:0] pl;
		margin_t m;
		int p;
		pl = '0;
		m = '0;
		case (s)
			SetLeftX: pl[RegLeft] = make_plane(NormOne, 0, 0, 0);
			SetAllCulled: m = margin_t'(-1);
			SetZeroSum: begin
				pl[RegFar] = make_plane(0, 0, 0, -DistOne);
				m = margin_t'(MarginOne);
			end
			SetExtremeA: begin
				for (p = 0; p < NumPlanes; p++)
					pl[p] = make_plane(NormMin, NormMax, 0, CMax);
				m = margin_t'(MarginMin);
			end
			SetExtremeB: begin
				for (p = 0; p < NumPlanes; p++)
					pl[p] = make_plane(NormMax, NormMin, -1, CMin);
				m = margin_t'(MarginMax);
			end
			default: ;
		endcase
		load_config(pl, m);
	endtask

	task automatic load_random_config();
		plane_t [NumPlanes-1:0] pl;
		margin_t m;
		int p;
		for (p = 0; p < NumPlanes; p++) begin
			pl[p] = {$urandom(), $urandom()};
			case ($urandom_range(3))
				1: pl[p].distance = dist_t'($urandom_range(0, CMax));
				2: pl[p].distance = dist_t'(int'($urandom_range(0, 8192)) - 4096);
				3: pl[p] = '0;
				default: ;
			endcase
		end
		case ($urandom_range(5))
			0: m = margin_t'(MarginMin);
			1: m = margin_t'(MarginMax);
			2: m = margin_t'($urandom());
			default: m = margin_t'(int'($urandom_range(0, 512)) - 256);
		endcase
		load_config(pl, m);
	endtask

	task automatic send_box(input vec3_t lo, input vec3_t hi, input logic typed, input logic vis);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		low_x <= lo.x;
		low_y <= lo.y;
		low_z <= lo.z;
		high_x <= hi.x;
		high_y <= hi.y;
		high_z <= hi.z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_visible.push_back(typed ? vis : box_visible(lo, hi));
	endtask

	// stop offering boxes and wait for every visible bit to come back
	task automatic drain_boxes();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_visible.size() != 0);
	endtask

	always @(posedge clk) begin : collect_visible
		logic want;
		if (out_valid && !out_stall) begin
			if (pending_visible.size() == 0) begin
				report_mismatch($sformatf("visible=%b with no box outstanding", visible));
			end else begin
				want = pending_visible.pop_front();
				if (visible !== want)
					report_mismatch($sformatf("visible=%b, predicted %b", visible, want));
			end
			results_seen++;
		end
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= LongHold;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		box_row_t row;
		plane_set_t cur_set;
		vec3_t lo;
		vec3_t hi;
		int i;
		int phase;
		int b;
		int n;
		send_idle_pct = 37;
		recv_idle_pct = 49;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		cur_set = SetReset;
		for (i = 0; i < NumRows; i++) begin
			row = directed_boxes[i];
			if (row.pset != cur_set) begin
				drain_boxes();
				apply_set(row.pset);
				cur_set = row.pset;
			end
			lo.x = coord_t'(row.lx);
			lo.y = coord_t'(row.ly);
			lo.z = coord_t'(row.lz);
			hi.x = coord_t'(row.hx);
			hi.y = coord_t'(row.hy);
			hi.z = coord_t'(row.hz);
			send_box(lo, hi, row.typed, row.vis);
		end

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 49;
				end
				1: begin
					send_idle_pct = 49;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (b = 0; b < BatchesPerPhase; b++) begin
				drain_boxes();
				load_random_config();
				// full-rate sender against a long output hold fills the pipe
				if (phase == 2 && (b == 0 || b == 3))
					hold_req <= hold_req + 1;
				for (n = 0; n < BoxesPerBatch; n++) begin
					if ($urandom_range(199) == 0)
						drain_boxes();
					rand_box(lo, hi);
					send_box(lo, hi, 1'b0, 1'b0);
				end
			end
		end

		drain_boxes();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
